[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, operation codes and the control types shared
// by the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = COLUMNS * ROWS;
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int SRC_W  = $clog2(CELLS + COLUMNS + 1);

  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCROLL_PRIME,
    ST_SCROLL,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_input;
    logic rd_next;
    logic put_step;
    logic home;
    logic sweep_write;
    logic copy;
    logic load_result;
    logic result_read;
    logic result_scrolled;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic scroll_needed;
    logic sweep_last;
    logic out_busy;
  } dp_status_t;

endpackage

[rtl/core/tcw_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one console operation per beat.
// ----------------------------------------------------------------------------
interface tcw_req_if;

  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::OP_W-1:0]     operation;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::ATTR_W-1:0]   attribute;
  logic [tcw_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, output operation, output char_code, output attribute,
                  output cell_index, input ready);
  modport sink   (input valid, input operation, input char_code, input attribute,
                  input cell_index, output ready);

endinterface

[rtl/core/tcw_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface tcw_rsp_if;

  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::POS_W-1:0]   cursor_position;
  logic [tcw_pkg::CELL_W-1:0]  cell_value;
  logic                        scrolled;

  modport source (output valid, output cursor_position, output cell_value,
                  output scrolled, input ready);
  modport sink   (input valid, input cursor_position, input cell_value,
                  input scrolled, output ready);

endinterface

[rtl/core/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// Text console controller
// State machine that sequences decode, scroll copy, screen clear and the
// clearing pass after reset, and drives the datapath by commands.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tcw_pkg::dp_status_t status,
  output tcw_pkg::dp_cmd_t    cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    req_ready  = 1'b0;
    state_next = state;
    case (state)
      tcw_pkg::ST_INIT: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        cmd.rd_input = 1'b1;
        req_ready    = !status.out_busy;
        if (req_valid && !status.out_busy) begin
          cmd.accept = 1'b1;
          state_next = tcw_pkg::ST_DECODE;
        end
      end
      tcw_pkg::ST_DECODE: begin
        case (status.op)
          tcw_pkg::OP_PUT: begin
            cmd.put_step = 1'b1;
            if (status.scroll_needed) begin
              state_next = tcw_pkg::ST_SCROLL_PRIME;
            end else begin
              cmd.load_result = 1'b1;
              state_next      = tcw_pkg::ST_IDLE;
            end
          end
          tcw_pkg::OP_READ: begin
            cmd.load_result = 1'b1;
            cmd.result_read = 1'b1;
            state_next      = tcw_pkg::ST_IDLE;
          end
          tcw_pkg::OP_CLEAR: begin
            cmd.home   = 1'b1;
            state_next = tcw_pkg::ST_CLEAR;
          end
          default: begin
            cmd.load_result = 1'b1;
            state_next      = tcw_pkg::ST_IDLE;
          end
        endcase
      end
      tcw_pkg::ST_SCROLL_PRIME: begin
        state_next = tcw_pkg::ST_SCROLL;
      end
      tcw_pkg::ST_SCROLL: begin
        cmd.sweep_write = 1'b1;
        cmd.copy        = 1'b1;
        cmd.rd_next     = 1'b1;
        if (status.sweep_last) begin
          cmd.load_result     = 1'b1;
          cmd.result_scrolled = 1'b1;
          state_next          = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          cmd.load_result = 1'b1;
          state_next      = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_INIT;
      end
    endcase
  end

endmodule

[rtl/core/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// Text console datapath
// Screen memory, cursor registers, sweep counter, item registers and the
// result register.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tcw_pkg::dp_cmd_t              cmd,
  output tcw_pkg::dp_status_t           status,
  input  logic [tcw_pkg::OP_W-1:0]      req_operation,
  input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
  input  logic [tcw_pkg::ATTR_W-1:0]    req_attribute,
  input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
  input  logic                          rsp_ready,
  output logic                          rsp_valid,
  output logic [tcw_pkg::POS_W-1:0]     rsp_cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_value,
  output logic                          rsp_scrolled
);

  logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELLS];
  logic [tcw_pkg::CELL_W-1:0] rdata;

  tcw_pkg::op_t                op_q;
  logic [tcw_pkg::CHAR_W-1:0]  char_q;
  logic [tcw_pkg::ATTR_W-1:0]  attr_q;
  logic                        idx_ok_q;

  logic [tcw_pkg::COL_W-1:0]   col;
  logic [tcw_pkg::COL_W-1:0]   col_next;
  logic [tcw_pkg::ADDR_W-1:0]  row_base;
  logic [tcw_pkg::ADDR_W-1:0]  row_base_next;
  logic [tcw_pkg::ADDR_W-1:0]  cnt;

  logic [tcw_pkg::COL_W:0]     col_inc;
  logic                        printable;
  logic                        is_newline;
  logic                        wrap;
  logic                        scroll_needed;
  logic                        sweep_last;
  logic [tcw_pkg::ADDR_W-1:0]  put_addr;
  logic [tcw_pkg::ADDR_W-1:0]  pos_next;
  logic [tcw_pkg::SRC_W-1:0]   src;

  logic                        we;
  logic [tcw_pkg::ADDR_W-1:0]  waddr;
  logic [tcw_pkg::CELL_W-1:0]  wdata;
  logic [tcw_pkg::ADDR_W-1:0]  raddr;

  assign printable     = char_q inside {[tcw_pkg::PRINT_LO:tcw_pkg::PRINT_HI]};
  assign is_newline    = (char_q == tcw_pkg::NEWLINE);
  assign col_inc       = {1'b0, col} + (tcw_pkg::COL_W+1)'(1);
  assign wrap          = is_newline ||
                         (printable && (col_inc == (tcw_pkg::COL_W+1)'(tcw_pkg::COLUMNS)));
  assign scroll_needed = wrap && (row_base == tcw_pkg::ADDR_W'(tcw_pkg::LAST_ROW_BASE));
  assign sweep_last    = (cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));
  assign put_addr      = row_base + tcw_pkg::ADDR_W'(col);

  always_comb begin
    col_next      = col;
    row_base_next = row_base;
    if (cmd.home) begin
      col_next      = '0;
      row_base_next = '0;
    end else if (cmd.put_step) begin
      if (wrap) begin
        col_next = '0;
        if (!scroll_needed) begin
          row_base_next = row_base + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
        end
      end else if (printable) begin
        col_next = col_inc[tcw_pkg::COL_W-1:0];
      end
    end
  end

  assign pos_next = row_base_next + tcw_pkg::ADDR_W'(col_next);

  assign src = tcw_pkg::SRC_W'(cnt) + tcw_pkg::SRC_W'(tcw_pkg::COLUMNS) +
               tcw_pkg::SRC_W'(cmd.rd_next);

  always_comb begin
    if (cmd.rd_input) begin
      raddr = (req_cell_index < tcw_pkg::CELLS) ? tcw_pkg::ADDR_W'(req_cell_index) : '0;
    end else begin
      raddr = (src < tcw_pkg::CELLS) ? tcw_pkg::ADDR_W'(src) : '0;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cnt;
    wdata = tcw_pkg::BLANK_CELL;
    if (cmd.sweep_write) begin
      we = 1'b1;
      if (cmd.copy && (cnt < tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS))) begin
        wdata = rdata;
      end
    end else if (cmd.put_step && printable) begin
      we    = 1'b1;
      waddr = put_addr;
      wdata = {attr_q, char_q};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= tcw_pkg::op_t'(req_operation);
      char_q   <= req_char_code;
      attr_q   <= req_attribute;
      idx_ok_q <= (req_cell_index < tcw_pkg::CELLS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row_base <= '0;
      cnt      <= '0;
    end else begin
      col      <= col_next;
      row_base <= row_base_next;
      if (cmd.sweep_write) begin
        cnt <= sweep_last ? '0 : cnt + tcw_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp_cursor_position <= tcw_pkg::POS_W'(pos_next);
      rsp_cell_value      <= (cmd.result_read && idx_ok_q) ? rdata : '0;
      rsp_scrolled        <= cmd.result_scrolled;
    end
  end

  assign status.op            = op_q;
  assign status.scroll_needed = scroll_needed;
  assign status.sweep_last    = sweep_last;
  assign status.out_busy      = rsp_valid && !rsp_ready;

endmodule

[rtl/core/text_console_writer.sv]
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell screen of attribute/character cells with a cursor, put,
// read and clear operations, line wrap and scroll.
// ----------------------------------------------------------------------------
// Put, read and no-op items are registered on acceptance, decoded in the
// decode state and answered from the result register; the next item is
// accepted back in idle once no result beat is stalled. A put that scrolls
// primes the read and then copies rows up, walking the write and read ports
// of the screen memory one cell per cycle; a clear blanks every cell. After
// reset a clearing pass blanks the screen while req.ready is held low.
module text_console_writer (
  input logic       clk,
  input logic       rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);

  tcw_pkg::dp_cmd_t    cmd;
  tcw_pkg::dp_status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .req_operation       (req.operation),
    .req_char_code       (req.char_code),
    .req_attribute       (req.attribute),
    .req_cell_index      (req.cell_index),
    .rsp_ready           (rsp.ready),
    .rsp_valid           (rsp.valid),
    .rsp_cursor_position (rsp.cursor_position),
    .rsp_cell_value      (rsp.cell_value),
    .rsp_scrolled        (rsp.scrolled)
  );

endmodule

[rtl/core/tcw_checker.sv]
// ----------------------------------------------------------------------------
// Text console checker
// Port-level assertions on the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [tcw_pkg::POS_W-1:0]    rsp_cursor_position,
  input logic [tcw_pkg::CELL_W-1:0]   rsp_cell_value,
  input logic                         rsp_scrolled
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_position) &&
      $stable(rsp_cell_value) && $stable(rsp_scrolled))
    else $error("Stalled response beat changed or dropped.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("Second request beat accepted while one is in progress.");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_cursor_position < tcw_pkg::CELLS)
    else $error("Cursor position lies outside the screen.");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_scrolled |->
      rsp_cursor_position == tcw_pkg::POS_W'(tcw_pkg::LAST_ROW_BASE))
    else $error("Scroll did not leave the cursor at the start of the last row.");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_cursor_position (rsp.cursor_position),
  .rsp_cell_value      (rsp.cell_value),
  .rsp_scrolled        (rsp.scrolled)
);

[dv/text_console_writer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, read, clear and unused-code requests with random gaps and
// applies random backpressure on the result side. A local screen and cursor
// model predicts each result when its request beat is accepted. Results are
// checked in order, field by field, against those predictions.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

  import tcw_pkg::*;

  typedef struct {
    op_t                op;
    logic [CHAR_W-1:0]  ch;
    logic [ATTR_W-1:0]  attr;
    logic [INDEX_W-1:0] idx;
  } console_cmd_t;

  typedef struct {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } console_result_t;

  logic clk;
  logic rst;

  tcw_req_if req_bus ();
  tcw_rsp_if rsp_bus ();

  text_console_writer DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  console_cmd_t    pending_cmds[$];
  console_result_t expected_results[$];
  console_cmd_t    cmd_on_bus;
  console_result_t want;

  logic [CELL_W-1:0] screen_mem [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;

  int  send_wait    = 0;
  int  recv_wait    = 0;
  bit  send_quiet   = 1'b0;
  bit  recv_quiet   = 1'b0;
  int  useful_items = 0;
  int  mismatches   = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_idle(ref bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic console_result_t apply_command(console_cmd_t c);
    console_result_t r;
    int unsigned     i;
    r.cell_value = '0;
    r.scrolled   = 1'b0;
    case (c.op)
      OP_PUT: begin
        if (c.ch >= PRINT_LO && c.ch <= PRINT_HI) begin
          screen_mem[cur_row * COLUMNS + cur_col] = {c.attr, c.ch};
          cur_col++;
        end else if (c.ch == NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
          for (i = CELLS - COLUMNS; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      OP_READ: begin
        if (c.idx < CELLS) r.cell_value = screen_mem[c.idx];
      end
      OP_CLEAR: begin
        for (i = 0; i < CELLS; i++) screen_mem[i] = BLANK_CELL;
        cur_col = 0;
        cur_row = 0;
      end
      default: ;
    endcase
    r.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  task automatic queue_command(op_t op, logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr,
                               logic [INDEX_W-1:0] idx);
    console_cmd_t c;
    c.op   = op;
    c.ch   = ch;
    c.attr = attr;
    c.idx  = idx;
    pending_cmds.push_back(c);
    if (op != OP_NOP &&
        !(op == OP_PUT && ch != NEWLINE && (ch < PRINT_LO || ch > PRINT_HI)))
      useful_items++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (mismatches < 40)
      $display("text_console_writer_tb: mismatch in %s: got %0h, expected %0h at %0t",
               what, got, exp_val, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid      <= 1'b0;
      req_bus.operation  <= '0;
      req_bus.char_code  <= '0;
      req_bus.attribute  <= '0;
      req_bus.cell_index <= '0;
    end else begin
      if (req_bus.valid && req_bus.ready) expected_results.push_back(apply_command(cmd_on_bus));
      if (!req_bus.valid || req_bus.ready) begin
        if (send_wait > 0 || pending_cmds.size() == 0) begin
          req_bus.valid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end else begin
          cmd_on_bus = pending_cmds.pop_front();
          req_bus.valid      <= 1'b1;
          req_bus.operation  <= cmd_on_bus.op;
          req_bus.char_code  <= cmd_on_bus.ch;
          req_bus.attribute  <= cmd_on_bus.attr;
          req_bus.cell_index <= cmd_on_bus.idx;
          send_wait = draw_idle(send_quiet);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 32'(rsp_bus.cursor_position), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_bus.cursor_position !== want.pos)
            report_mismatch("cursor_position", 32'(rsp_bus.cursor_position), 32'(want.pos));
          if (rsp_bus.cell_value !== want.cell_value)
            report_mismatch("cell_value", 32'(rsp_bus.cell_value), 32'(want.cell_value));
          if (rsp_bus.scrolled !== want.scrolled)
            report_mismatch("scrolled", 32'(rsp_bus.scrolled), 32'(want.scrolled));
        end
        recv_wait = draw_idle(recv_quiet);
      end
      if (recv_wait > 0) begin
        rsp_bus.ready <= 1'b0;
        if (rsp_bus.valid && !rsp_bus.ready) recv_wait--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("text_console_writer_tb: FAIL");
    $finish;
  end

  initial begin
    int                 line_len;
    int                 n;
    int                 k;
    logic [CHAR_W-1:0]  ch;
    logic [ATTR_W-1:0]  attr;
    logic [INDEX_W-1:0] idx;

    rst = 1'b1;

    for (k = 0; k < CELLS; k++) screen_mem[k] = BLANK_CELL;
    cur_col = 0;
    cur_row = 0;

    queue_command(OP_READ, 8'h00, 8'h00, 11'd0);
    queue_command(OP_READ, 8'hFF, 8'hFF, 11'd2047);
    queue_command(OP_PUT, PRINT_LO, 8'h00, 11'd0);
    queue_command(OP_PUT, PRINT_HI, 8'hFF, 11'd2047);
    queue_command(OP_PUT, 8'h1F, 8'h3C, 11'd5);
    queue_command(OP_PUT, 8'h00, 8'hC3, 11'd0);
    queue_command(OP_PUT, 8'h80, 8'h11, 11'd0);
    queue_command(OP_PUT, 8'hFF, 8'hEE, 11'd0);
    queue_command(OP_PUT, NEWLINE, 8'h00, 11'd0);
    queue_command(OP_READ, 8'h00, 8'h00, 11'd0);
    queue_command(OP_READ, 8'h00, 8'h00, 11'd1);
    queue_command(OP_READ, 8'h00, 8'h00, 11'd2);
    queue_command(OP_NOP, 8'hA5, 8'h5A, 11'd1234);
    queue_command(OP_READ, 8'h00, 8'h00, 11'(CELLS - 1));
    queue_command(OP_READ, 8'h00, 8'h00, 11'(CELLS));
    queue_command(OP_PUT, 8'h41, 8'h1E, 11'd0);
    queue_command(OP_CLEAR, 8'hFF, 8'hFF, 11'd2047);
    queue_command(OP_READ, 8'h00, 8'h00, 11'd0);
    queue_command(OP_READ, 8'h00, 8'h00, 11'(COLUMNS));
    queue_command(OP_PUT, 8'h5A, 8'h70, 11'd0);

    useful_items = 0;
    while (useful_items < 400) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 90) : $urandom_range(0, 12);
        attr     = 8'($urandom_range(0, 255));
        for (n = 0; n < line_len; n++) begin
          if ($urandom_range(0, 7) == 0) attr = 8'($urandom_range(0, 255));
          queue_command(OP_PUT, 8'($urandom_range(PRINT_LO, PRINT_HI)), attr,
                        11'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 99) < 85)
          queue_command(OP_PUT, NEWLINE, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
      end else if (k < 80) begin
        for (n = $urandom_range(1, 4); n > 0; n--) begin
          case ($urandom_range(0, 4))
            0, 1:    idx = 11'($urandom_range(LAST_ROW_BASE - COLUMNS, CELLS - 1));
            2, 3:    idx = 11'($urandom_range(0, CELLS - 1));
            default: idx = 11'($urandom_range(0, 2047));
          endcase
          queue_command(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), idx);
        end
      end else if (k < 92) begin
        for (n = $urandom_range(1, 3); n > 0; n--) begin
          if ($urandom_range(0, 2) == 0) begin
            queue_command(OP_NOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, 2047)));
          end else begin
            if ($urandom_range(0, 1) == 1) begin
              ch = 8'($urandom_range(8'h80, 8'hFF));
            end else begin
              do ch = 8'($urandom_range(0, 8'h1F)); while (ch == NEWLINE);
            end
            queue_command(OP_PUT, ch, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
          end
        end
      end else if (k < 99) begin
        case ($urandom_range(0, 2))
          0:       queue_command(OP_PUT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)));
          1:       queue_command(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)));
          default: queue_command(OP_NOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 11'($urandom_range(0, 2047)));
        endcase
      end else begin
        queue_command(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_cmds.size() != 0 || req_bus.valid || expected_results.size() != 0);
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("text_console_writer_tb: PASS");
    end else begin
      $display("text_console_writer_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tcw_pkg.sv
rtl/core/tcw_req_if.sv
rtl/core/tcw_rsp_if.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_checker.sv
dv/text_console_writer_tb.sv
